[hw/rtl/plane_segment_intersect_macros.svh]
// assertion macros for the plane / segment intersection block
// expects clk and arst_n in the scope of each use
`ifndef PLANE_SEGMENT_INTERSECT_MACROS_SVH
`define PLANE_SEGMENT_INTERSECT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PSI_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define PSI_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PSI_ASSERT_IMP(label, ante, cons, msg)
`define PSI_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

[hw/rtl/psi_pkg.sv]
// shared constants and register codes for the plane / segment intersection block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package psi_pkg;
	localparam int COORD_BITS_DEF    = 32;
	localparam int QUOTIENT_BITS_DEF = 24;
	localparam int FIELD_W           = 32;
	localparam int IN_TDATA_W        = 6 * FIELD_W;
	localparam int OUT_TDATA_W       = 3 * FIELD_W;
	localparam int CFG_IDX_W         = 2;
	localparam logic [FIELD_W-1:0] NORMAL_Z_RST = 32'h0001_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NORMAL_X,
		REG_NORMAL_Y,
		REG_NORMAL_Z,
		REG_PLANE_OFFSET
	} reg_idx_t;
endpackage
`default_nettype wire

[hw/rtl/plane_segment_intersect.sv]
// plane / segment intersection, pipelined, one segment per clock while the skid entry is empty
// depends on psi_pkg and plane_segment_intersect_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "plane_segment_intersect_macros.svh"

// The plane (normal and offset, signed Q16.16) sits in four registers written
// through cfg_we / cfg_idx / cfg_wdata. Each request on the slave side carries
// one segment; the block forms both endpoint distances, applies the sign rule and
// on a hit returns the crossing point, else zeros with the hit flag low. It
// takes one segment per clock and returns one result per clock. A result passes
// through six stages for the dot products, distances and operand setup, one
// restoring divider step per stage for each quotient bit, one scaling multiply
// stage and the output register. A one-entry skid buffer behind the output
// register keeps s_tready registered; while it is full the whole pipeline holds.
module plane_segment_intersect
	import psi_pkg::*;
#(
	parameter int COORD_BITS    = COORD_BITS_DEF,
	parameter int QUOTIENT_BITS = QUOTIENT_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration write port
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [FIELD_W-1:0]     cfg_wdata,
	// segment requests
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// start_x, start_y, start_z, end_x, end_y, end_z (32 bits each)
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// results
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// cross_x, cross_y, cross_z (32 bits each)
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	// hit
	output logic                        m_tuser
);

	// coordinates are read as this many low bits, sign extended
	localparam int CW = (COORD_BITS > FIELD_W) ? FIELD_W : COORD_BITS;
	localparam int QB = QUOTIENT_BITS;
	// sum of three products
	localparam int SW = 2 * CW + 1;
	// distance after dropping 16 fraction bits and subtracting the offset
	localparam int DW = 2 * CW - 14;
	// divider operands, wide enough for the distance difference
	localparam int NW = DW + 1;
	// quotient, one integer bit
	localparam int QW = QB + 1;
	// scaled difference product
	localparam int PW = CW + QW + 2;
	// pipeline depth
	localparam int NS = QB + 8;

	typedef struct packed {
		logic               hit;
		logic [2:0][CW-1:0] ps;    // endpoint with the smaller distance
		logic [2:0][CW:0]   diff;  // other endpoint minus that one
	} geo_t;

	// plane registers
	logic [FIELD_W-1:0] nrm_x_q, nrm_y_q, nrm_z_q, plane_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrm_x_q     <= '0;
			nrm_y_q     <= '0;
			nrm_z_q     <= NORMAL_Z_RST;
			plane_off_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_NORMAL_X:     nrm_x_q     <= cfg_wdata;
				REG_NORMAL_Y:     nrm_y_q     <= cfg_wdata;
				REG_NORMAL_Z:     nrm_z_q     <= cfg_wdata;
				REG_PLANE_OFFSET: plane_off_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic signed [CW-1:0] nrm [3];
	logic signed [CW-1:0] off;
	assign nrm[0] = $signed(nrm_x_q[CW-1:0]);
	assign nrm[1] = $signed(nrm_y_q[CW-1:0]);
	assign nrm[2] = $signed(nrm_z_q[CW-1:0]);
	assign off    = $signed(plane_off_q[CW-1:0]);

	// flow control: everything moves together unless the skid entry is full
	logic          en;
	logic          skid_vld_q;
	logic [NS:1]   vld_s;

	assign en       = ~skid_vld_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NS-1:1], s_tvalid};
		end
	end

	// endpoints out of the request
	logic signed [CW-1:0] pt_a [3];
	logic signed [CW-1:0] pt_b [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pt_a[i] = $signed(s_tdata[FIELD_W*i +: CW]);
			pt_b[i] = $signed(s_tdata[FIELD_W*(3+i) +: CW]);
		end
	end

	// stage 1: six products, normal times coordinate
	logic signed [2*CW-1:0] pa_s1 [3];
	logic signed [2*CW-1:0] pb_s1 [3];
	logic signed [CW-1:0]   a_s1 [3];
	logic signed [CW-1:0]   b_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pa_s1[i] <= nrm[i] * pt_a[i];
				pb_s1[i] <= nrm[i] * pt_b[i];
				a_s1[i]  <= pt_a[i];
				b_s1[i]  <= pt_b[i];
			end
		end
	end

	// stage 2: dot products at full precision
	logic signed [SW-1:0] sa_s2, sb_s2;
	logic signed [CW-1:0] a_s2 [3];
	logic signed [CW-1:0] b_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			sa_s2 <= SW'(pa_s1[0]) + SW'(pa_s1[1]) + SW'(pa_s1[2]);
			sb_s2 <= SW'(pb_s1[0]) + SW'(pb_s1[1]) + SW'(pb_s1[2]);
			a_s2  <= a_s1;
			b_s2  <= b_s1;
		end
	end

	// stage 3: distances, floor of the dot product minus the offset
	logic signed [DW-1:0] d0_s3, d1_s3;
	logic signed [CW-1:0] a_s3 [3];
	logic signed [CW-1:0] b_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			d0_s3 <= DW'($signed(sa_s2[SW-1:16])) - DW'(off);
			d1_s3 <= DW'($signed(sb_s2[SW-1:16])) - DW'(off);
			a_s3  <= a_s2;
			b_s3  <= b_s2;
		end
	end

	// stage 4: sign rule and distance difference
	logic                 hit_s4;
	logic signed [NW-1:0] dd_s4;
	logic signed [DW-1:0] d0_s4, d1_s4;
	logic signed [CW-1:0] a_s4 [3];
	logic signed [CW-1:0] b_s4 [3];
	logic                 d1_pos, d0_neg;

	assign d1_pos = !d1_s3[DW-1] && (d1_s3 != '0);
	assign d0_neg = d0_s3[DW-1];

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s4 <= (d1_pos == d0_neg) && (d0_s3 != d1_s3);
			dd_s4  <= NW'(d1_s3) - NW'(d0_s3);
			d0_s4  <= d0_s3;
			d1_s4  <= d1_s3;
			a_s4   <= a_s3;
			b_s4   <= b_s3;
		end
	end

	// stage 5: order the endpoints, divider operands, difference vector
	logic                 sel;     // start point has the smaller distance
	logic signed [DW-1:0] ds;
	logic signed [NW-1:0] ds_ext;
	geo_t                 geo_c;
	geo_t                 geo_s5;
	logic [NW-1:0]        num_s5, den_s5;

	assign sel    = !dd_s4[NW-1] && (dd_s4 != '0);
	assign ds     = sel ? d0_s4 : d1_s4;
	assign ds_ext = NW'(ds);

	always_comb begin
		geo_c.hit = hit_s4;
		for (int i = 0; i < 3; i++) begin
			geo_c.ps[i]   = sel ? a_s4[i] : b_s4[i];
			geo_c.diff[i] = sel ? ((CW+1)'(b_s4[i]) - (CW+1)'(a_s4[i]))
			                    : ((CW+1)'(a_s4[i]) - (CW+1)'(b_s4[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s5 <= geo_c;
			num_s5 <= ds_ext[NW-1] ? NW'(-ds_ext) : NW'(ds_ext);
			den_s5 <= sel ? NW'(dd_s4) : NW'(-dd_s4);
		end
	end

	// stage 6 and divider: entry 0 holds the integer bit, entry k quotient bit k
	logic [NW-1:0] rem_sd [QB+1];
	logic [NW-1:0] den_sd [QB+1];
	logic [QW-1:0] quo_sd [QB+1];
	geo_t          geo_sd [QB+1];
	logic          q_top;

	// numerator never exceeds the denominator on a hit, equal gives exactly one
	assign q_top = (num_s5 == den_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_sd[0] <= q_top ? '0 : num_s5;
			den_sd[0] <= den_s5;
			quo_sd[0] <= QW'(q_top);
			geo_sd[0] <= geo_s5;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_div
		logic [NW:0] shl;
		logic [NW:0] sub;
		logic        ge;

		assign shl = {rem_sd[k-1], 1'b0};
		assign sub = shl - {1'b0, den_sd[k-1]};
		assign ge  = shl >= {1'b0, den_sd[k-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[k] <= ge ? sub[NW-1:0] : shl[NW-1:0];
				den_sd[k] <= den_sd[k-1];
				quo_sd[k] <= {quo_sd[k-1][QW-2:0], ge};
				geo_sd[k] <= geo_sd[k-1];
			end
		end
	end

	// scaling multiply: difference times the fraction
	logic signed [PW-1:0] prod_sm [3];
	geo_t                 geo_sm;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_sm[i] <= $signed(geo_sd[QB].diff[i]) * $signed({1'b0, quo_sd[QB]});
			end
			geo_sm <= geo_sd[QB];
		end
	end

	// output register: point with the smaller distance plus the floored scaled difference
	logic signed [CW-1:0]      res [3];
	logic [2:0][FIELD_W-1:0]   out_q;
	logic                      hit_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			res[i] = $signed(geo_sm.ps[i]) + $signed(prod_sm[i][QB+CW-1:QB]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				out_q[i] <= geo_sm.hit ? FIELD_W'(res[i]) : '0;
			end
			hit_q <= geo_sm.hit;
		end
	end

	// skid entry: catches the output when it is not taken as the pipe moves on
	logic [OUT_TDATA_W-1:0] skid_data_q;
	logic                   skid_hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (en) begin
			skid_vld_q <= vld_s[NS] & ~m_tready;
		end else if (m_tready) begin
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_s[NS] && !m_tready) begin
			skid_data_q <= out_q;
			skid_hit_q  <= hit_q;
		end
	end

	// skid entry is always the older result
	assign m_tvalid = skid_vld_q | vld_s[NS];
	assign m_tdata  = skid_vld_q ? skid_data_q : out_q;
	assign m_tuser  = skid_vld_q ? skid_hit_q : hit_q;

	`PSI_ASSERT_NXT(a_skid_fill, !skid_vld_q && vld_s[NS] && !m_tready, skid_vld_q, "undelivered result not caught by skid entry")
	`PSI_ASSERT_NXT(a_skid_hold, skid_vld_q && !m_tready, skid_vld_q, "skid entry lost while stalled")
	`PSI_ASSERT_NXT(a_pipe_hold, skid_vld_q, $stable(vld_s), "pipeline moved while skid entry full")
	`PSI_ASSERT_IMP(a_miss_zero, m_tvalid && !m_tuser, m_tdata == '0, "miss with nonzero crossing point")

endmodule
`default_nettype wire

[sim/tb.sv]
// self-checking bench for plane_segment_intersect: directed segment table, then random phases
// depends on psi_pkg and the plane_segment_intersect rtl, nothing else
`timescale 1ns / 1ps

module tb;
	import psi_pkg::*;

	localparam int QB       = QUOTIENT_BITS_DEF;
	// requests travel QUOTIENT_BITS + 8 stages before the result shows up
	localparam int LATENCY  = QB + 8;
	localparam int PHASES   = 9;
	localparam int PER_PHASE = 215;
	localparam int LIMIT    = 300000;
	localparam int HOLD_OFF = 400;

	// handy q16.16 values
	localparam logic [31:0] ONE   = 32'h0001_0000;
	localparam logic [31:0] NEG1  = 32'hFFFF_0000;
	localparam logic [31:0] MOST  = 32'h8000_0000;
	localparam logic [31:0] LEAST = 32'h7FFF_FFFF;

	// one result as the block returns it
	typedef struct packed {
		logic        hit;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} crossing_t;

	localparam crossing_t MISS = '0;

	typedef struct {
		logic [IN_TDATA_W-1:0] seg;
		bit                    known;
		crossing_t             want;
	} segment_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_idx = REG_NORMAL_X;
	logic [FIELD_W-1:0]     cfg_wdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// start_x, start_y, start_z, end_x, end_y, end_z from the lowest bit up
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// cross_x, cross_y, cross_z from the lowest bit up
	logic [OUT_TDATA_W-1:0] m_tdata;
	// hit
	logic                   m_tuser;

	// bench copy of the plane, starts at the reset values
	logic [31:0] plane_nx  = '0;
	logic [31:0] plane_ny  = '0;
	logic [31:0] plane_nz  = NORMAL_Z_RST;
	logic [31:0] plane_off = '0;

	// side info that rides along with the request, kept in the bench beside the bus
	bit          row_known = 1'b0;
	crossing_t   row_want = MISS;

	crossing_t    pending_crossings[$];
	segment_row_t directed_rows[$];
	int           mismatch_count = 0;
	int           results_seen = 0;
	int           requests_taken = 0;
	int           cycle_count = 0;
	int           burst_left = 0;

	plane_segment_intersect #(
		.COORD_BITS   (COORD_BITS_DEF),
		.QUOTIENT_BITS(QB)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// signed distance of one point, exact: floor(dot / 2^16) - offset
	function automatic logic signed [79:0] plane_distance(logic signed [79:0] px,
			logic signed [79:0] py, logic signed [79:0] pz);
		logic signed [79:0] acc;
		acc = $signed(plane_nx) * px + $signed(plane_ny) * py + $signed(plane_nz) * pz;
		return (acc >>> 16) - $signed(plane_off);
	endfunction

	// expected result of one segment request under the current plane
	function automatic crossing_t predict_crossing(logic [IN_TDATA_W-1:0] seg);
		logic signed [79:0] start_pt [3];
		logic signed [79:0] end_pt [3];
		logic signed [79:0] d0, d1, ds, ps, diff, prod, v;
		logic [79:0]        num, den;
		logic [127:0]       q;
		logic [31:0]        pt_out [3];
		logic               start_low;
		crossing_t          res;
		for (int i = 0; i < 3; i++) begin
			start_pt[i] = $signed(seg[i*32 +: 32]);
			end_pt[i]   = $signed(seg[(i+3)*32 +: 32]);
		end
		d0  = plane_distance(start_pt[0], start_pt[1], start_pt[2]);
		d1  = plane_distance(end_pt[0], end_pt[1], end_pt[2]);
		res = MISS;
		// sign rule kept as the block defines it, equal distances never hit
		if (((d1 > 0) == (d0 < 0)) && (d0 != d1)) begin
			start_low = d0 < d1;
			ds  = start_low ? d0 : d1;
			num = (ds < 0) ? -ds : ds;
			den = (start_low ? d1 : d0) - ds;
			// fraction of the way from the low end, 0 .. 2^QB
			q   = ({48'd0, num} << QB) / {48'd0, den};
			for (int i = 0; i < 3; i++) begin
				ps   = start_low ? start_pt[i] : end_pt[i];
				diff = (start_low ? end_pt[i] : start_pt[i]) - ps;
				prod = diff * $signed({1'b0, q[QB:0]});
				v    = ps + (prod >>> QB);
				pt_out[i] = v[31:0];
			end
			res.hit = 1'b1;
			res.x   = pt_out[0];
			res.y   = pt_out[1];
			res.z   = pt_out[2];
		end
		return res;
	endfunction

	// mostly full-range values, with mid-size values, the corners and zero mixed in
	function automatic logic [31:0] pick_coord();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0: return MOST;
			1: return LEAST;
			2: return 32'h0;
			3, 4, 5: return {{11{r[20]}}, r[20:0]};
			default: return r;
		endcase
	endfunction

	function automatic logic [31:0] small_fixed();
		logic [31:0] r;
		r = $urandom;
		return {{14{r[17]}}, r[17:0]};
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatch_count < 40)
			$display("mismatch in %s at result %0d: got %h, expected %h",
				what, results_seen, got, want);
		mismatch_count++;
	endtask

	task automatic add_row(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
			logic [31:0] ex, logic [31:0] ey, logic [31:0] ez, bit known, crossing_t want);
		segment_row_t row;
		row.seg   = {ez, ey, ex, sz, sy, sx};
		row.known = known;
		row.want  = want;
		directed_rows.push_back(row);
	endtask

	// all four plane registers back to back, called on a rising edge while idle
	task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
			logic [31:0] off);
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_NORMAL_X;
		cfg_wdata <= nx;
		@(posedge clk);
		cfg_idx   <= REG_NORMAL_Y;
		cfg_wdata <= ny;
		@(posedge clk);
		cfg_idx   <= REG_NORMAL_Z;
		cfg_wdata <= nz;
		@(posedge clk);
		cfg_idx   <= REG_PLANE_OFFSET;
		cfg_wdata <= off;
		@(posedge clk);
		cfg_we    <= 1'b0;
		plane_nx  = nx;
		plane_ny  = ny;
		plane_nz  = nz;
		plane_off = off;
	endtask

	// offer one segment request, hold it until taken, then maybe leave a gap
	task automatic offer_segment(logic [IN_TDATA_W-1:0] seg, bit known, crossing_t want);
		int gap;
		s_tvalid  <= 1'b1;
		s_tdata   <= seg;
		row_known <= known;
		row_want  <= want;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// stop sending and wait for every pending result
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_crossings.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// scoreboard: requests go in on the slave side, results are checked in order
	always @(posedge clk) begin : result_check
		crossing_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				pending_crossings.push_back(row_known ? row_want : predict_crossing(s_tdata));
				requests_taken <= requests_taken + 1;
			end
			if (m_tvalid && m_tready) begin
				if (pending_crossings.size() == 0) begin
					report_mismatch("result with nothing pending", m_tdata[31:0], 32'h0);
				end else begin
					want = pending_crossings.pop_front();
					if (m_tuser !== want.hit)
						report_mismatch("hit", {31'd0, m_tuser}, {31'd0, want.hit});
					if (m_tdata[31:0] !== want.x)
						report_mismatch("cross_x", m_tdata[31:0], want.x);
					if (m_tdata[63:32] !== want.y)
						report_mismatch("cross_y", m_tdata[63:32], want.y);
					if (m_tdata[95:64] !== want.z)
						report_mismatch("cross_z", m_tdata[95:64], want.z);
				end
				results_seen++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side: stall patterns of its own, plus one long hold-off that backs
	// the pipeline up into the request side
	initial begin : result_stalls
		int  mode;
		int  left;
		bit  hold_done;
		mode      = 0;
		left      = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && requests_taken >= 400) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(16, 300);
				end
				left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 1);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		logic [31:0] c [6];
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed table, reset plane is z = 0 so distances are just the z values
		// plain crossing, halfway
		add_row(0, 0, NEG1, 32'h0002_0000, 32'h0004_0000, ONE, 1,
			{1'b1, ONE, 32'h0002_0000, 32'h0});
		// same segment walked the other way
		add_row(0, 0, ONE, 32'h0002_0000, 32'h0004_0000, NEG1, 1,
			{1'b1, ONE, 32'h0002_0000, 32'h0});
		// both ends above
		add_row(ONE, ONE, ONE, 32'h0003_0000, 32'h0003_0000, 32'h0002_0000, 1, MISS);
		// both ends on the plane, equal distances
		add_row(32'h0007_0000, 32'h0008_0000, 0, 32'h0009_0000, 32'h000A_0000, 0, 1, MISS);
		// equal nonzero distances below
		add_row(ONE, 32'h0002_0000, 32'hFFFD_0000, 32'h0004_0000, 32'h0005_0000,
			32'hFFFD_0000, 1, MISS);
		// start on plane, end below: hit at the start point
		add_row(32'h0005_0000, 32'h0006_0000, 0, 32'h0007_0000, 32'h0008_0000, NEG1, 1,
			{1'b1, 32'h0005_0000, 32'h0006_0000, 32'h0});
		// end on plane, start above: hit at the end point
		add_row(32'h0005_0000, 32'h0006_0000, ONE, 32'h0007_0000, 32'h0008_0000, 0, 1,
			{1'b1, 32'h0007_0000, 32'h0008_0000, 32'h0});
		// start on plane, end above: miss by the sign rule
		add_row(32'h0005_0000, 32'h0006_0000, 0, 32'h0007_0000, 32'h0008_0000, ONE, 1, MISS);
		// end on plane, start below: miss by the sign rule
		add_row(32'h0005_0000, 32'h0006_0000, NEG1, 32'h0007_0000, 32'h0008_0000, 0, 1, MISS);
		// degenerate segments
		add_row(MOST, MOST, MOST, MOST, MOST, MOST, 1, MISS);
		add_row(0, 0, 0, 0, 0, 0, 1, MISS);
		// full-range corners, left to the predictor
		add_row(MOST, MOST, MOST, LEAST, LEAST, LEAST, 0, MISS);
		add_row(LEAST, LEAST, LEAST, MOST, MOST, MOST, 0, MISS);
		add_row(LEAST, MOST, 32'hFFFF_FFFF, MOST, LEAST, 32'h0000_0001, 0, MISS);
		// uneven fraction
		add_row(0, 0, NEG1, 32'h1234_5678, 32'hEDCB_A988, 32'h0002_0000, 0, MISS);
		add_row(32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF, 32'h7654_3210, 32'h0FED_CBA9,
			LEAST, 0, MISS);
		foreach (directed_rows[i])
			offer_segment(directed_rows[i].seg, directed_rows[i].known, directed_rows[i].want);
		drain_results();

		// random phases, each under its own plane
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: set_plane(0, 0, ONE, small_fixed());
				1: set_plane(small_fixed(), small_fixed(), small_fixed(), small_fixed());
				2: set_plane(MOST, MOST, MOST, LEAST);
				3: set_plane(LEAST, LEAST, LEAST, MOST);
				4: set_plane(ONE, ONE, ONE, 0);
				5: set_plane(0, 0, 0, $urandom);
				8: set_plane(0, 0, NEG1, small_fixed());
				default: set_plane($urandom, $urandom, $urandom, $urandom);
			endcase
			for (int k = 0; k < PER_PHASE; k++) begin
				foreach (c[i])
					c[i] = pick_coord();
				// z plane: put endpoints right on the plane now and then
				if (ph == 0 && $urandom_range(0, 5) == 0)
					c[2] = plane_off;
				if (ph == 0 && $urandom_range(0, 5) == 0)
					c[5] = plane_off;
				offer_segment({c[5], c[4], c[3], c[2], c[1], c[0]}, 0, MISS);
			end
			drain_results();
		end

		repeat (LATENCY + 8) @(posedge clk);
		if (mismatch_count == 0 && pending_crossings.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
